// ===== hdl/tpit_pkg.sv =====
// shared types and constants for the touch pointer id tracker
`default_nettype none
package tpit_pkg;
    typedef enum logic [3:0] {
        S_COLLECT,
        S_START,
        S_SCAN_RD,
        S_SCAN_MUL,
        S_SCAN_CMP,
        S_COMMIT,
        S_FILL,
        S_COPY,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic store_pt;
        logic clr_match;
        logic scan_first;
        logic scan_rd;
        logic scan_mul;
        logic scan_cmp;
        logic commit;
        logic fill;
        logic copy;
        logic emit_load;
        logic emit_next;
        logic special_seq;
        logic special_keep;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic fill_last;
        logic copy_last;
        logic emit_last;
        logic cnt_zero;
        logic prev_zero;
        logic both_one;
        logic match_done;
    } t_sts;
endpackage
`default_nettype wire

// ===== hdl/touch_pointer_id_tracker.sv =====
// top level of the touch pointer id tracker
// Points of a frame are taken one item a cycle; the item with tlast set closes
// the frame. The start state then picks the case. In the general case, id
// assignment runs greedy nearest-neighbor matching on one shared distance unit:
// each matching round scans all n*m current/previous pairs through read,
// multiply and compare steps and then commits the best pair, for min(n,m)
// rounds, then fills unmatched ids point by point. Every frame with points is
// then saved point by point. Results then leave one item a cycle while the
// output is ready. No input is taken until the last result of a frame is
// delivered. Ties go to the lowest current, then lowest previous index.
`default_nettype none
module touch_pointer_id_tracker import tpit_pkg::*; #(
    parameter int MAX_POINTS = 10,
    parameter int COORD_BITS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    // pos_x, pos_y, point_present
    input  wire [8*((2*COORD_BITS+1+7)/8)-1:0] s_axis_tdata,
    input  wire                       s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    // point_index, point_id, point_valid, id_mask
    output logic [8*((2*$clog2(MAX_POINTS+1)+1+MAX_POINTS+7)/8)-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);
    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int OW = 2 * IW + 1 + MAX_POINTS;
    localparam int OB = 8 * ((OW + 7) / 8);

    t_cmd w_cmd;
    t_sts w_sts;
    logic [IW-1:0] w_idx, w_id;
    logic w_pv;
    logic [MAX_POINTS-1:0] w_mask;
    logic w_in_fire, w_out_fire;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    tpit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_frame_end (s_axis_tlast),
        .i_out_fire  (w_out_fire),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    tpit_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_pos_x         (s_axis_tdata[COORD_BITS-1:0]),
        .i_pos_y         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_point_present (s_axis_tdata[2*COORD_BITS]),
        .o_sts           (w_sts),
        .o_point_index   (w_idx),
        .o_point_id      (w_id),
        .o_point_valid   (w_pv),
        .o_id_mask       (w_mask),
        .o_run_end       (m_axis_tlast)
    );

    assign m_axis_tdata = OB'({w_mask, w_pv, w_id, w_idx});
endmodule
`default_nettype wire

// ===== hdl/tpit_ctrl.sv =====
// controller state machine for the touch pointer id tracker
`default_nettype none
module tpit_ctrl import tpit_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_fire,
    input  wire        i_frame_end,
    input  wire        i_out_fire,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_COLLECT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.store_pt = 1'b1;
                    if (i_frame_end) n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.clr_match = 1'b1;
                if (i_sts.cnt_zero) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = S_EMIT;
                end else if (i_sts.prev_zero) begin
                    o_cmd.special_seq = 1'b1;
                    n_state = S_COPY;
                end else if (i_sts.both_one) begin
                    o_cmd.special_keep = 1'b1;
                    n_state = S_COPY;
                end else begin
                    o_cmd.scan_first = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SCAN_MUL;
            end
            S_SCAN_MUL: begin
                o_cmd.scan_mul = 1'b1;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state = i_sts.scan_last ? S_COMMIT : S_SCAN_RD;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (i_sts.match_done || !i_sts.found) n_state = S_FILL;
                else begin
                    o_cmd.scan_first = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) n_state = S_COPY;
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.copy_last) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_fire) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_sts.emit_last) n_state = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/tpit_dp.sv =====
// point stores, distance unit and id bookkeeping
`default_nettype none
module tpit_dp import tpit_pkg::*; #(
    parameter int MAX_POINTS = 10,
    parameter int COORD_BITS = 16,
    parameter int IW         = $clog2(MAX_POINTS + 1),
    parameter int XW         = $clog2(MAX_POINTS)
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_cmd                        i_cmd,
    input  wire signed [COORD_BITS-1:0] i_pos_x,
    input  wire signed [COORD_BITS-1:0] i_pos_y,
    input  wire                         i_point_present,
    output t_sts                        o_sts,
    output logic [IW-1:0]               o_point_index,
    output logic [IW-1:0]               o_point_id,
    output logic                        o_point_valid,
    output logic [MAX_POINTS-1:0]       o_id_mask,
    output logic                        o_run_end
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW + 1;

    logic signed [COORD_BITS-1:0] r_cx [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_cy [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_px [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_py [MAX_POINTS];
    logic [IW-1:0] r_pid [MAX_POINTS];
    logic [IW-1:0] r_cid [MAX_POINTS];
    logic [IW-1:0] r_ccnt, r_pcnt;
    logic [MAX_POINTS-1:0] r_mc, r_mp, r_used;
    logic [XW-1:0] r_c, r_p, r_bc, r_bp, r_idx;
    logic [SW-1:0] r_best;
    logic r_found;
    logic [DW-1:0] r_dx, r_dy;
    logic [2*DW-1:0] r_sx, r_sy;
    logic r_pair_ok, r_pair_ok2;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_eidx;

    logic [IW-1:0] w_c_ext, w_p_ext, w_i_ext;
    logic w_c_end, w_p_end, w_i_end;
    logic [SW-1:0] w_d;
    logic [IW-1:0] w_free;
    logic [IW-1:0] w_k_lim;

    assign w_c_ext = IW'(r_c);
    assign w_p_ext = IW'(r_p);
    assign w_i_ext = IW'(r_idx);
    assign w_p_end = (w_p_ext + 1'b1 == r_pcnt);
    assign w_c_end = (w_c_ext + 1'b1 == r_ccnt);
    assign w_i_end = (w_i_ext + 1'b1 == r_ccnt);
    assign w_d = SW'(r_sx) + SW'(r_sy);
    assign w_k_lim = (r_ccnt < r_pcnt) ? r_ccnt : r_pcnt;

    always_comb begin
        w_free = '0;
        for (int i = MAX_POINTS - 1; i >= 0; i--) begin
            if (!r_used[i]) w_free = IW'(i);
        end
    end

    always_comb begin
        o_sts = '0;
        o_sts.scan_last  = w_c_end && w_p_end;
        o_sts.found      = r_found;
        o_sts.fill_last  = w_i_end;
        o_sts.copy_last  = w_i_end;
        o_sts.emit_last  = (r_ccnt == '0) || (r_eidx + 1'b1 == r_ccnt);
        o_sts.cnt_zero   = (r_ccnt == '0);
        o_sts.prev_zero  = (r_pcnt == '0);
        o_sts.both_one   = (r_ccnt == IW'(1)) && (r_pcnt == IW'(1));
        o_sts.match_done = (r_k + 1'b1 == w_k_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pt && i_point_present && r_ccnt < IW'(MAX_POINTS)) begin
            r_cx[r_ccnt[XW-1:0]] <= i_pos_x;
            r_cy[r_ccnt[XW-1:0]] <= i_pos_y;
        end
        if (i_cmd.scan_rd) begin
            r_pair_ok <= !r_mc[r_c] && !r_mp[r_p];
            r_dx <= (r_cx[r_c] >= r_px[r_p])
                ? DW'(DW'(r_cx[r_c]) - DW'(r_px[r_p]))
                : DW'(DW'(r_px[r_p]) - DW'(r_cx[r_c]));
            r_dy <= (r_cy[r_c] >= r_py[r_p])
                ? DW'(DW'(r_cy[r_c]) - DW'(r_py[r_p]))
                : DW'(DW'(r_py[r_p]) - DW'(r_cy[r_c]));
        end
        if (i_cmd.scan_mul) begin
            r_sx <= r_dx * r_dx;
            r_sy <= r_dy * r_dy;
            r_pair_ok2 <= r_pair_ok;
        end
        if (i_cmd.special_seq) begin
            for (int i = 0; i < MAX_POINTS; i++) r_cid[i] <= IW'(i);
        end
        if (i_cmd.special_keep) r_cid[0] <= r_pid[0];
        if (i_cmd.commit && r_found) r_cid[r_bc] <= r_pid[r_bp];
        if (i_cmd.fill && !r_mc[r_idx]) r_cid[r_idx] <= w_free;
        if (i_cmd.copy) begin
            r_px[r_idx]  <= r_cx[r_idx];
            r_py[r_idx]  <= r_cy[r_idx];
            r_pid[r_idx] <= r_cid[r_idx];
        end
        if (i_cmd.scan_first) begin
            r_found <= 1'b0;
            r_c <= '0;
            r_p <= '0;
        end
        if (i_cmd.scan_cmp) begin
            if (r_pair_ok2 && (!r_found || w_d < r_best)) begin
                r_found <= 1'b1;
                r_best  <= w_d;
                r_bc    <= r_c;
                r_bp    <= r_p;
            end
            if (w_p_end) begin
                r_p <= '0;
                r_c <= XW'(w_c_ext + 1'b1);
            end else begin
                r_p <= XW'(w_p_ext + 1'b1);
            end
        end
        if (i_cmd.clr_match) begin
            r_idx <= '0;
            r_k   <= '0;
        end
        if (i_cmd.commit) begin
            r_k <= r_k + 1'b1;
            if (!(r_k + 1'b1 == w_k_lim) && r_found) r_idx <= '0;
        end
        if (i_cmd.fill || i_cmd.copy)
            r_idx <= w_i_end ? '0 : XW'(w_i_ext + 1'b1);
        if (i_cmd.emit_load) r_eidx <= '0;
        if (i_cmd.emit_next) r_eidx <= r_eidx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
            r_pcnt <= '0;
            r_mc   <= '0;
            r_mp   <= '0;
            r_used <= '0;
        end else begin
            if (i_cmd.store_pt && i_point_present && r_ccnt < IW'(MAX_POINTS))
                r_ccnt <= r_ccnt + 1'b1;
            if (i_cmd.clr_match) begin
                r_mc <= '0;
                r_mp <= '0;
            end
            if (i_cmd.special_seq) begin
                for (int i = 0; i < MAX_POINTS; i++)
                    r_used[i] <= (IW'(i) < r_ccnt);
            end else if (i_cmd.special_keep) begin
                r_used <= MAX_POINTS'(1) << r_pid[0];
            end else if (i_cmd.clr_match) begin
                r_used <= '0;
            end
            if (i_cmd.commit && r_found) begin
                r_mc[r_bc] <= 1'b1;
                r_mp[r_bp] <= 1'b1;
                r_used <= r_used | (MAX_POINTS'(1) << r_pid[r_bp]);
            end
            if (i_cmd.fill && !r_mc[r_idx])
                r_used <= r_used | (MAX_POINTS'(1) << w_free);
            if (i_cmd.emit_next && o_sts.emit_last) begin
                r_pcnt <= r_ccnt;
                r_ccnt <= '0;
            end
        end
    end

    always_comb begin
        o_point_index = r_eidx;
        o_point_valid = (r_ccnt != '0);
        o_point_id    = o_point_valid ? r_cid[r_eidx[XW-1:0]] : '0;
        o_id_mask     = r_used;
        o_run_end     = o_sts.emit_last;
    end
endmodule
`default_nettype wire

// ===== hdl/tpit_checker.sv =====
// port-level checks for the touch pointer id tracker
`default_nettype none
module tpit_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       s_axis_tready,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire       m_axis_tlast,
    input wire [3:0] idx,
    input wire       pv
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("in and out overlap");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid drop");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> idx == 4'd0) else $error("first index not zero");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !pv |-> m_axis_tlast) else $error("empty frame not last");
endmodule

bind touch_pointer_id_tracker tpit_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .idx           (m_axis_tdata[3:0]),
    .pv            (m_axis_tdata[8])
);
`default_nettype wire
